// ===== src/clipped_color_key_blitter_core_assert.svh =====
// Assertion macros for the blitter RTL.
`ifndef CLIPPED_COLOR_KEY_BLITTER_CORE_ASSERT_SVH
`define CLIPPED_COLOR_KEY_BLITTER_CORE_ASSERT_SVH

// Checked at every rising edge of clk once reset has been released.
`define CCKB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define CCKB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/cckb_pkg.sv =====
package cckb_pkg;

  // Largest source side the counters can walk.
  localparam int MAX_SIDE = 4096;
  localparam int CNT_W    = $clog2(MAX_SIDE);

  // Register and field widths fixed by the programming model.
  localparam int SIDE_W   = 13;
  localparam int KEY_W    = 24;
  localparam int PIX_W    = 32;
  localparam int ADDR_W   = 24;
  localparam int CFG_D_W  = 24;

  // Signed destination position: room for offset plus counter plus sign.
  localparam int POS_W    = ((CNT_W > SIDE_W) ? CNT_W : SIDE_W) + 2;
  localparam int PROD_W   = POS_W - 1 + SIDE_W;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_DST_WIDTH  = 3'd2,
    CFG_DST_HEIGHT = 3'd3,
    CFG_DST_X      = 3'd4,
    CFG_DST_Y      = 3'd5,
    CFG_KEY_COLOR  = 3'd6,
    CFG_KEY_ENABLE = 3'd7
  } cfg_idx_t;

  // Clamp a side register to 1..MAX_SIDE and return the last position.
  function automatic logic [CNT_W-1:0] last_pos(input logic [SIDE_W-1:0] side);
    logic [31:0] s;
    s = 32'(side);
    if (s == 32'd0) begin
      s = 32'd1;
    end else if (s > 32'(MAX_SIDE)) begin
      s = 32'(MAX_SIDE);
    end
    return CNT_W'(s - 32'd1);
  endfunction

endpackage

// ===== src/clipped_color_key_blitter_core.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_stall      in_src_pixel
// out      output     out_valid / out_stall    out_write_enable, out_dst_address,
//                                              out_dst_pixel, out_last_pixel
// cfg      input      cfg_we                   cfg_index, cfg_wdata
//
// One pixel per clock sustained while out_stall is low; a result passes the input and output registers.
// The input register holds the destination position, the output register holds the
// clip, key and address (one 14x13 multiply) result.
// Synchronous active-low reset clears valid flags, counters and config, but sets the sides to one.
// An output stall holds both stages; the input stage still takes a pixel while it is empty.
module clipped_color_key_blitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cckb_pkg::PIX_W-1:0]    in_src_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_enable,
  output logic [cckb_pkg::ADDR_W-1:0]   out_dst_address,
  output logic [cckb_pkg::PIX_W-1:0]    out_dst_pixel,
  output logic                          out_last_pixel,
  input  logic                          cfg_we,
  input  cckb_pkg::cfg_idx_t            cfg_index,
  input  logic [cckb_pkg::CFG_D_W-1:0]  cfg_wdata
);
  import cckb_pkg::*;

  `include "clipped_color_key_blitter_core_assert.svh"

  logic [SIDE_W-1:0] src_width_r, src_height_r, dst_width_r, dst_height_r;
  logic [SIDE_W-1:0] dst_x_r, dst_y_r;
  logic [KEY_W-1:0]  key_color_r;
  logic              key_enable_r;

  logic [CNT_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0]  row_cnt_r, row_cnt_nxt;

  logic              s1_valid_r;
  logic [POS_W-1:0]  s1_col_r, s1_row_r;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic              s1_last_r;

  logic              out_valid_r;
  logic              out_we_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_last_r;

  logic              adv2, adv1, in_xfer;
  logic              row_end, last;
  logic [POS_W-1:0]  col_pos, row_pos;
  logic [POS_W-2:0]  col_u, row_u;
  logic              in_bounds, keyed, we;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SIDE_W'(1);
      src_height_r <= SIDE_W'(1);
      dst_width_r  <= SIDE_W'(1);
      dst_height_r <= SIDE_W'(1);
      dst_x_r      <= '0;
      dst_y_r      <= '0;
      key_color_r  <= '0;
      key_enable_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_wdata[SIDE_W-1:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_DST_HEIGHT: dst_height_r <= cfg_wdata[SIDE_W-1:0];
        CFG_DST_X:      dst_x_r      <= cfg_wdata[SIDE_W-1:0];
        CFG_DST_Y:      dst_y_r      <= cfg_wdata[SIDE_W-1:0];
        CFG_KEY_COLOR:  key_color_r  <= cfg_wdata[KEY_W-1:0];
        CFG_KEY_ENABLE: key_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the output register frees when empty or taken.
  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;
  assign in_xfer  = in_valid && adv1;

  // Raster counters; a counter past a shrunken bound acts as the end.
  assign row_end = col_cnt_r >= last_pos(src_width_r);
  assign last    = row_end && (row_cnt_r >= last_pos(src_height_r));

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_xfer) begin
      if (row_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last ? '0 : row_cnt_r + CNT_W'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CNT_W'(1);
      end
    end
  end

  assign col_pos = POS_W'($signed(dst_x_r)) + POS_W'(col_cnt_r);
  assign row_pos = POS_W'($signed(dst_y_r)) + POS_W'(row_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      if (adv1) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_col_r   <= col_pos;
      s1_row_r   <= row_pos;
      s1_pixel_r <= in_src_pixel;
      s1_last_r  <= last;
    end
  end

  // Clip, key and address.
  assign col_u     = s1_col_r[POS_W-2:0];
  assign row_u     = s1_row_r[POS_W-2:0];
  assign in_bounds = !s1_col_r[POS_W-1] && !s1_row_r[POS_W-1] &&
                     (col_u < (POS_W-1)'(dst_width_r)) &&
                     (row_u < (POS_W-1)'(dst_height_r));
  assign keyed     = key_enable_r && (s1_pixel_r[KEY_W-1:0] == key_color_r);
  assign we        = in_bounds && !keyed;
  assign prod      = PROD_W'(row_u) * PROD_W'(dst_width_r);
  assign addr      = we ? (ADDR_W'(col_u) + ADDR_W'(prod)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_we_r    <= we;
      out_addr_r  <= addr;
      out_pixel_r <= s1_pixel_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_dst_address  = out_addr_r;
  assign out_dst_pixel    = out_pixel_r;
  assign out_last_pixel   = out_last_r;

  `CCKB_ASSERT(a_addr_zero, out_valid_r && !out_we_r |-> out_addr_r == '0, "stray address")
  `CCKB_ASSERT(a_wrap, in_xfer && last |=> col_cnt_r == '0 && row_cnt_r == '0, "no wrap")
  `CCKB_ASSERT(a_full, s1_valid_r && out_valid_r && out_stall |-> in_stall, "taken when full")
  `CCKB_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "busy after reset")

endmodule

// ===== test/tb_clipped_color_key_blitter_core.sv =====
module tb_clipped_color_key_blitter_core;
  import cckb_pkg::*;

  localparam int RANDOM_PIXELS = 800;
  localparam int CALM_TAIL     = 150;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic              write_enable;
    logic [ADDR_W-1:0] dst_address;
    logic [PIX_W-1:0]  dst_pixel;
    logic              last_pixel;
  } blit_write_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PIX_W-1:0]   in_src_pixel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_write_enable;
  logic [ADDR_W-1:0]  out_dst_address;
  logic [PIX_W-1:0]   out_dst_pixel;
  logic               out_last_pixel;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = CFG_SRC_WIDTH;
  logic [CFG_D_W-1:0] cfg_wdata = '0;

  // Register mirror and raster counters, as the block holds them.
  logic [SIDE_W-1:0]        src_w = SIDE_W'(1), src_h = SIDE_W'(1);
  logic [SIDE_W-1:0]        dst_w = SIDE_W'(1), dst_h = SIDE_W'(1);
  logic signed [SIDE_W-1:0] off_x = '0, off_y = '0;
  logic [KEY_W-1:0]         key_rgb = '0;
  logic                     key_on = 1'b0;
  logic [11:0]              col_cnt = '0, row_cnt = '0;

  blit_write_t predicted_writes[$];
  blit_write_t want_w;

  bit gaps_on = 1'b1, stalls_on = 1'b1;
  int gap_pct = 20, stall_pct = 20;
  int err_count = 0, pixels_sent = 0, results_checked = 0, reg_writes = 0;
  int writes_hit = 0, images_done = 0, cycle_count = 0;

  clipped_color_key_blitter_core dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_last(logic [SIDE_W-1:0] side);
    int s;
    s = int'(side);
    if (s == 0) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s - 1;
  endfunction

  // Works out where one source pixel lands and advances the raster position.
  function automatic blit_write_t place_pixel(logic [PIX_W-1:0] pix);
    blit_write_t r;
    int  col, row;
    bit  in_bounds, keyed, row_end;
    col       = int'(off_x) + int'(col_cnt);
    row       = int'(off_y) + int'(row_cnt);
    in_bounds = col >= 0 && row >= 0 && col < int'(dst_w) && row < int'(dst_h);
    keyed     = key_on && pix[23:0] == key_rgb;
    row_end   = int'(col_cnt) >= clamp_last(src_w);
    r.write_enable = in_bounds && !keyed;
    r.dst_address  = r.write_enable ? ADDR_W'(col + row * int'(dst_w)) : '0;
    r.dst_pixel    = pix;
    r.last_pixel   = row_end && int'(row_cnt) >= clamp_last(src_h);
    if (row_end) begin
      col_cnt = '0;
      row_cnt = r.last_pixel ? 12'd0 : row_cnt + 12'd1;
    end else begin
      col_cnt = col_cnt + 12'd1;
    end
    return r;
  endfunction

  // Side and offset registers are 13 bits; the upper data bits are don't-care.
  function automatic logic [CFG_D_W-1:0] side_word(int v);
    return {11'($urandom), 13'(v)};
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_D_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH:  src_w = val[SIDE_W-1:0];
      CFG_SRC_HEIGHT: src_h = val[SIDE_W-1:0];
      CFG_DST_WIDTH:  dst_w = val[SIDE_W-1:0];
      CFG_DST_HEIGHT: dst_h = val[SIDE_W-1:0];
      CFG_DST_X:      off_x = val[SIDE_W-1:0];
      CFG_DST_Y:      off_y = val[SIDE_W-1:0];
      CFG_KEY_COLOR:  key_rgb = val[KEY_W-1:0];
      CFG_KEY_ENABLE: key_on = val[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    if (gaps_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_src_pixel <= pix;
    do @(posedge clk); while (in_stall);
    predicted_writes.push_back(place_pixel(pix));
    pixels_sent++;
  endtask

  // Drains the pipeline so the registers can be rewritten safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_writes.size() == 0) begin
        $error("result transfer with nothing predicted");
        err_count++;
      end else begin
        want_w = predicted_writes.pop_front();
        results_checked++;
        if (out_write_enable !== want_w.write_enable) begin
          $error("write_enable: expected %0d, got %0d", want_w.write_enable, out_write_enable);
          err_count++;
        end
        if (out_dst_address !== want_w.dst_address) begin
          $error("dst_address: expected %0h, got %0h", want_w.dst_address, out_dst_address);
          err_count++;
        end
        if (out_dst_pixel !== want_w.dst_pixel) begin
          $error("dst_pixel: expected %0h, got %0h", want_w.dst_pixel, out_dst_pixel);
          err_count++;
        end
        if (out_last_pixel !== want_w.last_pixel) begin
          $error("last_pixel: expected %0d, got %0d", want_w.last_pixel, out_last_pixel);
          err_count++;
        end
        if (want_w.write_enable) writes_hit++;
        if (want_w.last_pixel) images_done++;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // With the reset registers every pixel is a one-pixel image at address zero.
  task automatic test_reset_defaults();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    settle();
  endtask

  task automatic test_clip_and_key();
    write_reg(CFG_SRC_WIDTH, side_word(3));
    write_reg(CFG_SRC_HEIGHT, side_word(2));
    write_reg(CFG_DST_WIDTH, side_word(4));
    write_reg(CFG_DST_HEIGHT, side_word(3));
    write_reg(CFG_DST_X, side_word(-1));
    write_reg(CFG_DST_Y, side_word(1));
    write_reg(CFG_KEY_COLOR, 24'h12_3456);
    write_reg(CFG_KEY_ENABLE, 24'h00_0001);
    // The reserved byte must not defeat the key match.
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hAB12_3456);
    send_pixel(32'h0012_3457);
    send_pixel(32'h0013_3456);
    send_pixel(32'h0012_3556);
    send_pixel(32'hFF12_3456);
    settle();
    write_reg(CFG_KEY_ENABLE, 24'h00_0000);
    send_pixel(32'h0012_3456);
    send_pixel(32'hAB12_3456);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h5A5A_5A5A);
    send_pixel(32'hA5A5_A5A5);
    settle();
  endtask

  task automatic test_size_edges();
    // Zero source sides act as one; a zero-wide destination takes nothing.
    write_reg(CFG_SRC_WIDTH, side_word(0));
    write_reg(CFG_SRC_HEIGHT, side_word(0));
    write_reg(CFG_DST_WIDTH, side_word(0));
    write_reg(CFG_DST_X, side_word(0));
    write_reg(CFG_DST_Y, side_word(0));
    send_pixel(32'h0102_0304);
    send_pixel(32'h8070_6050);
    settle();
    // Oversized destination at the far corner: the address wraps.
    write_reg(CFG_SRC_WIDTH, side_word(2));
    write_reg(CFG_SRC_HEIGHT, side_word(2));
    write_reg(CFG_DST_WIDTH, side_word(8191));
    write_reg(CFG_DST_HEIGHT, side_word(8191));
    write_reg(CFG_DST_X, side_word(4095));
    write_reg(CFG_DST_Y, side_word(4095));
    repeat (4) send_pixel($urandom);
    settle();
    // Shrink the source mid-row so the column counter lies past the new edge.
    write_reg(CFG_SRC_WIDTH, side_word(5));
    write_reg(CFG_SRC_HEIGHT, side_word(5));
    write_reg(CFG_DST_X, side_word(-4096));
    write_reg(CFG_DST_Y, side_word(-4096));
    repeat (3) send_pixel($urandom);
    settle();
    write_reg(CFG_SRC_WIDTH, side_word(2));
    write_reg(CFG_DST_X, side_word(0));
    write_reg(CFG_DST_Y, side_word(0));
    repeat (2) send_pixel($urandom);
    settle();
  endtask

  function automatic int pick_src_side();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return $urandom_range(MAX_SIDE + 1, 8191);
      2: return MAX_SIDE;
      default: return $urandom_range(1, 9);
    endcase
  endfunction

  function automatic int pick_dst_side();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom_range(13, 8191);
      2: return 8191;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 15))
      0: return -4096;
      1: return 4095;
      2: return $urandom_range(0, 8191) - 4096;
      default: return $urandom_range(0, 24) - 12;
    endcase
  endfunction

  // Pixels lean toward the key color so keying decisions come up often.
  function automatic logic [PIX_W-1:0] pick_pixel();
    logic [PIX_W-1:0] p;
    p = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: p[23:0] = key_rgb;
      3:       p[23:0] = key_rgb ^ (24'd1 << $urandom_range(0, 23));
      4:       p = $urandom_range(0, 1) ? '0 : '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_random_frames();
    int sent, n, area;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if (sent >= RANDOM_PIXELS - CALM_TAIL) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      write_reg(CFG_SRC_WIDTH, side_word(pick_src_side()));
      write_reg(CFG_SRC_HEIGHT, side_word(pick_src_side()));
      write_reg(CFG_DST_WIDTH, side_word(pick_dst_side()));
      write_reg(CFG_DST_HEIGHT, side_word(pick_dst_side()));
      write_reg(CFG_DST_X, side_word(pick_offset()));
      write_reg(CFG_DST_Y, side_word(pick_offset()));
      write_reg(CFG_KEY_COLOR, 24'($urandom));
      write_reg(CFG_KEY_ENABLE, {23'($urandom), 1'($urandom_range(0, 1))});
      area = (clamp_last(src_w) + 1) * (clamp_last(src_h) + 1);
      // Mostly whole images; sometimes a cut-off stream to leave counters mid-image.
      if (area <= 40 && $urandom_range(0, 3) != 0)
        n = area * $urandom_range(1, 3);
      else
        n = $urandom_range(1, 40);
      repeat (n) send_pixel(pick_pixel());
      sent += n;
      settle();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_clip_and_key();
    test_size_edges();
    test_random_frames();
    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d pixels over %0d register writes; checked %0d results.",
             pixels_sent, reg_writes, results_checked);
    $display("Predicted %0d destination writes and %0d completed images.",
             writes_hit, images_done);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/cckb_pkg.sv
src/clipped_color_key_blitter_core.sv
test/tb_clipped_color_key_blitter_core.sv
